// ----- rtl/core/psi_pkg.sv -----
// Shared constants for the polyline segment interpolator.
package psi_pkg;

    localparam int MaxPoints   = 64;
    localparam int CordicSteps = 20;
    localparam int CordW       = 52;
    localparam int ZW          = 27;

    localparam logic [6:0]  ResetPoints = 7'd10;
    localparam logic [16:0] HeadingTurn = 17'd92160;
    localparam logic [16:0] HeadingHalf = 17'd46080;
    localparam logic signed [ZW-1:0] HalfTurn = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] FullTurn = ZW'(360 * 65536);

    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0:    atan_entry = 22'd2949120;
            5'd1:    atan_entry = 22'd1740967;
            5'd2:    atan_entry = 22'd919879;
            5'd3:    atan_entry = 22'd466945;
            5'd4:    atan_entry = 22'd234379;
            5'd5:    atan_entry = 22'd117304;
            5'd6:    atan_entry = 22'd58666;
            5'd7:    atan_entry = 22'd29335;
            5'd8:    atan_entry = 22'd14668;
            5'd9:    atan_entry = 22'd7334;
            5'd10:   atan_entry = 22'd3667;
            5'd11:   atan_entry = 22'd1833;
            5'd12:   atan_entry = 22'd917;
            5'd13:   atan_entry = 22'd458;
            5'd14:   atan_entry = 22'd229;
            5'd15:   atan_entry = 22'd115;
            5'd16:   atan_entry = 22'd57;
            5'd17:   atan_entry = 22'd29;
            5'd18:   atan_entry = 22'd14;
            5'd19:   atan_entry = 22'd7;
            default: atan_entry = 22'd0;
        endcase
    endfunction

endpackage

// ----- rtl/core/polyline_segment_interpolator_core.sv -----
// Top level of the polyline segment interpolator.
//
//  channel | dir | handshake             | payload
//  s_axis  | in  | s_axis_tvalid/tready  | tdata {lon[28:0], lat[27:0]}, tuser path_start
//  m_axis  | out | m_axis_tvalid/tready  | tdata {hdg, lon, lat}, tlast segment_last
//  cfg     | in  | i_cfg_valid/o_cfg_ready | points_per_segment
//
// A starting waypoint is only stored. A continuing waypoint first runs the
// CORDIC, then for each of N points one shared 36-step restoring divider is
// run for latitude and again for longitude before the output beat. The block
// takes no beat while busy. Reset is synchronous; the output holds while
// m_axis_tready is low.
module polyline_segment_interpolator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // latitude[27:0], longitude[56:28], zero fill
    input  logic        s_axis_tuser,  // path_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // point_latitude, point_longitude, heading, zero fill
    output logic        m_axis_tlast,  // segment_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data     // points_per_segment
);
    typedef enum logic [2:0] {S_IDLE, S_HEAD, S_DLAT, S_DLON, S_OUT} t_state;
    t_state r_state;

    logic signed [27:0] r_prev_lat, r_lat2, r_plat;
    logic signed [28:0] r_prev_lon, r_lon2, r_plon;
    logic        r_have;
    logic [6:0]  r_npts, r_n, r_j;
    logic [16:0] r_head;
    logic        r_out_valid, r_last;
    logic        r_div_start, r_cor_start;

    logic signed [27:0] in_lat;
    logic signed [28:0] in_lon;
    assign in_lat = s_axis_tdata[27:0];
    assign in_lon = s_axis_tdata[56:28];

    // Shared divider operand: j times the delta of the current axis.
    logic signed [29:0] dsel;
    logic signed [35:0] prod;
    assign dsel = (r_state == S_DLAT) ? (30'(r_lat2) - 30'(r_prev_lat))
                                      : (30'(r_lon2) - 30'(r_prev_lon));
    assign prod = 36'(dsel) * $signed({1'b0, r_j});

    logic               div_done;
    logic signed [29:0] quot;

    psi_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start), .i_num(prod),
        .i_den(r_n), .o_done(div_done), .o_quot(quot)
    );

    logic        cor_done;
    logic [16:0] cor_head;
    psi_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_cor_start),
        .i_x(29'(r_prev_lat) - 29'(r_lat2)), .i_y(30'(r_prev_lon) - 30'(r_lon2)),
        .o_done(cor_done), .o_heading(cor_head)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_prev_lat  <= '0;
            r_prev_lon  <= '0;
            r_npts      <= psi_pkg::ResetPoints;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_cor_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_cor_start <= 1'b0;
            if (i_cfg_valid) r_npts <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser || !r_have) begin
                            r_prev_lat <= in_lat;
                            r_prev_lon <= in_lon;
                            r_have     <= 1'b1;
                        end else begin
                            r_lat2 <= in_lat;
                            r_lon2 <= in_lon;
                            r_j    <= '0;
                            if (r_npts == 7'd0) r_n <= 7'd1;
                            else if (r_npts > 7'(psi_pkg::MaxPoints)) r_n <= 7'(psi_pkg::MaxPoints);
                            else r_n <= r_npts;
                            r_cor_start <= 1'b1;
                            r_state     <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    if (cor_done) begin
                        r_head      <= cor_head;
                        r_div_start <= 1'b1;
                        r_state     <= S_DLAT;
                    end
                end
                S_DLAT: begin
                    if (div_done) begin
                        r_plat      <= 28'(30'(r_prev_lat) + quot);
                        r_div_start <= 1'b1;
                        r_state     <= S_DLON;
                    end
                end
                S_DLON: begin
                    if (div_done) begin
                        r_plon      <= 29'(30'(r_prev_lon) + quot);
                        r_last      <= (r_j == r_n - 7'd1);
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        if (r_last) begin
                            r_prev_lat <= r_lat2;
                            r_prev_lon <= r_lon2;
                            r_state    <= S_IDLE;
                        end else begin
                            r_j         <= r_j + 7'd1;
                            r_div_start <= 1'b1;
                            r_state     <= S_DLAT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {6'd0, r_head, r_plon, r_plat};
endmodule

// ----- rtl/core/psi_cordic.sv -----
// Iterative vectoring CORDIC giving the segment heading in 1/256 degree.
module psi_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [28:0]   i_x,
    input  logic signed [29:0]   i_y,
    output logic                 o_done,
    output logic [16:0]          o_heading
);
    typedef enum logic [1:0] {S_IDLE, S_ITER, S_WRAP, S_ROUND} t_state;
    t_state r_state;
    logic signed [psi_pkg::CordW-1:0] r_x, r_y;
    logic signed [psi_pkg::ZW-1:0]    r_z;
    logic [4:0]  r_i;
    logic        r_zero;
    logic [16:0] r_heading;
    logic        r_done;

    logic signed [psi_pkg::CordW-1:0] xs, ys;
    logic signed [psi_pkg::ZW-1:0]    at;
    logic [psi_pkg::ZW-1:0]           rnd;
    assign xs  = r_x >>> r_i;
    assign ys  = r_y >>> r_i;
    assign at  = psi_pkg::ZW'(psi_pkg::atan_entry(r_i));
    assign rnd = (psi_pkg::ZW'(r_z) + psi_pkg::ZW'(128)) >> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_zero <= (i_x == 0) && (i_y == 0);
                        r_i    <= 5'd0;
                        if (i_x < 0) begin
                            r_x <= -(psi_pkg::CordW'(i_x) <<< 20);
                            r_y <= -(psi_pkg::CordW'(i_y) <<< 20);
                            r_z <= '0;
                        end else begin
                            r_x <= psi_pkg::CordW'(i_x) <<< 20;
                            r_y <= psi_pkg::CordW'(i_y) <<< 20;
                            r_z <= psi_pkg::HalfTurn;
                        end
                        r_state <= S_ITER;
                    end
                end
                S_ITER: begin
                    if (!r_y[psi_pkg::CordW-1]) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + at;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - at;
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(psi_pkg::CordicSteps - 1)) r_state <= S_WRAP;
                end
                S_WRAP: begin
                    if (r_z < 0) r_z <= r_z + psi_pkg::FullTurn;
                    else if (r_z >= psi_pkg::FullTurn) r_z <= r_z - psi_pkg::FullTurn;
                    else r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (r_zero) r_heading <= psi_pkg::HeadingHalf;
                    else if (17'(rnd) >= psi_pkg::HeadingTurn) r_heading <= '0;
                    else r_heading <= 17'(rnd);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_heading = r_heading;
endmodule

// ----- rtl/core/psi_divider.sv -----
// Restoring divider: signed numerator over a small unsigned count, truncating.
module psi_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [35:0]  i_num,
    input  logic [6:0]          i_den,
    output logic                o_done,
    output logic signed [29:0]  o_quot
);
    logic [35:0] r_q;
    logic [6:0]  r_rem, r_den;
    logic        r_neg, r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [7:0]  trial;
    assign trial = {r_rem, r_q[35]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg  <= i_num[35];
                r_q    <= i_num[35] ? 36'(-i_num) : i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_den}) begin
                    r_rem <= 7'(trial - {1'b0, r_den});
                    r_q   <= {r_q[34:0], 1'b1};
                end else begin
                    r_rem <= trial[6:0];
                    r_q   <= {r_q[34:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd35) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -30'(r_q) : 30'(r_q);
endmodule

// ----- tb/sv/polyline_segment_interpolator_core_tb.sv -----
// Self-checking testbench for the polyline segment interpolator core.
module polyline_segment_interpolator_core_tb;

    localparam int  ClkHalf    = 5;
    localparam int  CycleLimit = 3000000;
    localparam int  SettleCyc  = 300;
    localparam int  LongHold   = 4000;
    localparam longint LatHi   = 94371840;
    localparam longint LonHi   = 188743680;

    // Arc tangent of 2^-i in units of 2^-16 degree.
    localparam longint ArcTab [psi_pkg::CordicSteps] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    // Point counts used by the random phases.
    localparam int PhasePts [10] = '{3, 1, 2, 5, 4, 2, 6, 3, 1, 2};

    typedef struct {
        logic [27:0] lat;
        logic [28:0] lon;
        logic        start;
    } t_waypoint;

    typedef struct {
        logic [27:0] lat;
        logic [28:0] lon;
        logic [16:0] hdg;
        logic        last;
    } t_track_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // latitude, longitude, zero fill
    logic        s_axis_tuser = 1'b0;  // path_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;         // point_latitude, point_longitude, heading, zero fill
    logic        m_axis_tlast;         // segment_last
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;      // points_per_segment

    polyline_segment_interpolator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #ClkHalf i_clk = ~i_clk;

    // Shadow of the block: previous waypoint, whether one exists, and point count.
    longint      last_lat = 0;
    longint      last_lon = 0;
    bit          have_last = 1'b0;
    logic [6:0]  seg_points = psi_pkg::ResetPoints;

    t_waypoint    waypoint_q [$];
    t_track_point track_q [$];
    t_waypoint    on_bus;
    int           mismatches = 0;
    int           cycle_cnt = 0;
    int           hold_left;
    bit           hold_done;

    // Segment heading: vectoring CORDIC on the backward difference, plus 180 degrees.
    function automatic logic [16:0] seg_heading(input longint dx, input longint dy);
        longint x, y, z, h, xs, ys;
        x = dx * 1048576;
        y = dy * 1048576;
        z = 0;
        if (dx == 0 && dy == 0) begin
            return psi_pkg::HeadingHalf;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            h = 0;
        end else begin
            h = 180 * 65536;
        end
        for (int i = 0; i < psi_pkg::CordicSteps; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ArcTab[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ArcTab[i];
            end
        end
        h = h + z;
        while (h < 0) h = h + 360 * 65536;
        while (h >= 360 * 65536) h = h - 360 * 65536;
        h = (h + 128) >>> 8;
        if (h >= 92160) h = 0;
        return h[16:0];
    endfunction

    // Expands one accepted waypoint into the points the block must emit.
    task automatic expand_waypoint(input t_waypoint w);
        longint lat2, lon2, n, dlat, dlon;
        logic [16:0] hdg;
        t_track_point p;
        lat2 = longint'(signed'(w.lat));
        lon2 = longint'(signed'(w.lon));
        if (w.start || !have_last) begin
            last_lat  = lat2;
            last_lon  = lon2;
            have_last = 1'b1;
            return;
        end
        n = seg_points;
        if (n < 1) n = 1;
        if (n > psi_pkg::MaxPoints) n = psi_pkg::MaxPoints;
        dlat = lat2 - last_lat;
        dlon = lon2 - last_lon;
        hdg  = seg_heading(last_lat - lat2, last_lon - lon2);
        for (longint j = 0; j < n; j++) begin
            // Signed division truncates toward zero, as the block must.
            p.lat  = 28'(last_lat + (j * dlat) / n);
            p.lon  = 29'(last_lon + (j * dlon) / n);
            p.hdg  = hdg;
            p.last = (j == n - 1);
            track_q.push_back(p);
        end
        last_lat = lat2;
        last_lon = lon2;
    endtask

    // Input driver: bursts of random length with random gaps in between.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        logic nv;
        nv = s_axis_tvalid;
        if (s_axis_tvalid && s_axis_tready) begin
            expand_waypoint(on_bus);
            nv = 1'b0;
        end
        if (!nv) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (i_rst_n && waypoint_q.size() > 0) begin
                on_bus = waypoint_q.pop_front();
                s_axis_tdata <= {7'd0, on_bus.lon, on_bus.lat};
                s_axis_tuser <= on_bus.start;
                nv = 1'b1;
                if (burst_left == 0) burst_left = $urandom_range(1, 8);
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
        s_axis_tvalid <= nv;
    end

    // Long receiver hold-off, triggered once while waypoints are still waiting.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && cycle_cnt > 20000 && waypoint_q.size() > 4) begin
            hold_left <= LongHold;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: alternates between always-ready stretches and random stalls.
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 400);
        end else begin
            mode_left--;
        end
        m_axis_tready <= (hold_left == 0) &&
                         (stall_mode == 0 || $urandom_range(0, stall_mode) == 0);
    end

    // Output monitor: every beat must match the oldest expected point.
    always @(posedge i_clk) begin
        t_track_point exp_pt;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (track_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat: tdata=%h tlast=%b",
                             m_axis_tdata, m_axis_tlast);
            end else begin
                exp_pt = track_q.pop_front();
                if (m_axis_tdata[27:0] !== exp_pt.lat ||
                    m_axis_tdata[56:28] !== exp_pt.lon ||
                    m_axis_tdata[73:57] !== exp_pt.hdg ||
                    m_axis_tlast !== exp_pt.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"point mismatch: exp lat=%h lon=%h hdg=%0d last=%b,",
                                  " got lat=%h lon=%h hdg=%0d last=%b"},
                                 exp_pt.lat, exp_pt.lon, exp_pt.hdg, exp_pt.last,
                                 m_axis_tdata[27:0], m_axis_tdata[56:28],
                                 m_axis_tdata[73:57], m_axis_tlast);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("polyline_segment_interpolator_core_tb: errors");
            $finish;
        end
    end

    task automatic add_wp(input longint lat, input longint lon, input bit start);
        t_waypoint w;
        w.lat   = 28'(lat);
        w.lon   = 29'(lon);
        w.start = start;
        waypoint_q.push_back(w);
    endtask

    // Waits until the block has drained and settled, so the register may change.
    task automatic drain();
        while (waypoint_q.size() > 0 || s_axis_tvalid || track_q.size() > 0)
            @(posedge i_clk);
        repeat (SettleCyc) @(posedge i_clk);
    endtask

    task automatic write_points(input logic [6:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        seg_points = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Random waypoint: mostly legal coordinates, sometimes raw full-width values or short hops.
    task automatic rand_path(input int legs, input bit lead_start);
        longint lat, lon;
        for (int k = 0; k <= legs; k++) begin
            case ($urandom_range(0, 9))
                0: begin
                    lat = longint'(signed'(28'($urandom)));
                    lon = longint'(signed'(29'($urandom)));
                end
                1: begin
                    // Short hop from the previous point, so deltas stay small.
                    lat = lat + longint'($urandom_range(0, 200)) - 100;
                    lon = lon + longint'($urandom_range(0, 200)) - 100;
                end
                default: begin
                    lat = longint'($urandom_range(0, 2 * LatHi)) - LatHi;
                    lon = longint'($urandom_range(0, 2 * LonHi)) - LonHi;
                end
            endcase
            add_wp(lat, lon, (k == 0) ? lead_start : ($urandom_range(0, 30) == 0));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset point count. The first waypoint has no
        // predecessor and no path-start flag, so it only gets stored.
        add_wp(0, 0, 0);
        add_wp(LatHi, LonHi, 0);
        add_wp(-LatHi, -LonHi, 0);
        add_wp(-LatHi, -LonHi, 0);            // identical points
        add_wp(LatHi, -LonHi, 0);             // backward difference negative in x
        add_wp(-LatHi, LonHi, 0);
        add_wp(0, 0, 1);
        add_wp(0, 5, 0);                      // equal latitudes
        add_wp(7, 5, 0);                      // equal longitudes
        add_wp(-(1 << 27), -(1 << 28), 1);    // most negative raw field values
        add_wp((1 << 27) - 1, (1 << 28) - 1, 0);
        add_wp(-(1 << 27), (1 << 28) - 1, 0);
        add_wp(-3, -3, 0);
        drain();

        // Point count extremes: zero is taken as one, above the maximum as the maximum.
        write_points(7'd0);
        add_wp(100, 200, 1);
        add_wp(-1000, 3000, 0);
        add_wp(LatHi, -LonHi, 0);
        write_points(7'd127);
        add_wp(0, 0, 1);
        add_wp(LatHi, LonHi, 0);
        add_wp(-12345, 777, 0);
        write_points(7'd64);
        add_wp(-LatHi, 0, 1);
        add_wp(0, -LonHi, 0);
        write_points(7'd1);
        rand_path(20, 1);

        // Random part, through several point counts.
        for (int p = 0; p < 10; p++) begin
            write_points(7'(PhasePts[p]));
            repeat (4) rand_path($urandom_range(3, 8), $urandom_range(0, 1));
        end
        write_points(7'd64);
        rand_path(3, 1);

        drain();
        if (mismatches == 0 && track_q.size() == 0) begin
            $display("polyline_segment_interpolator_core_tb: clean");
        end else begin
            $display("polyline_segment_interpolator_core_tb: errors");
        end
        $finish;
    end

endmodule
